/* hdl/rcs_pkg.sv */
// Package for the regression/correlation statistics block: types, codes and constants.
package rcs_pkg;

    // Parameter defaults
    localparam int DEF_MAX_PAIRS   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Widest pair count the snapshot carries (MAX_PAIRS up to 65536)
    localparam int CNT_MAX_W = 17;

    // Snapshot queue depth
    localparam int Q_DEPTH = 2;

    // Arithmetic constants
    localparam logic [40:0] Q_SAT      = 41'h100_0000_0000;   // quotient ceiling, 2^40
    localparam logic [40:0] CAP_POS32  = 41'h000_7FFF_FFFF;
    localparam logic [40:0] CAP_NEG32  = 41'h000_8000_0000;
    localparam logic [40:0] CAP_CORR   = 41'd16384;
    localparam logic [63:0] NORM_LIM   = 64'h1000_0000_0000_0000; // 2^60
    localparam logic [63:0] SQRT_TOP   = 64'h4000_0000_0000_0000; // 2^62
    localparam logic [63:0] DEV_MAX    = 64'd65535;
    localparam logic [6:0]  SLOPE_FRAC = 7'd16;
    localparam logic [6:0]  CORR_FRAC  = 7'd14;
    localparam logic [7:0]  MUL_LAST   = 8'd63;
    localparam logic [7:0]  SQRT_LAST  = 8'd31;
    localparam logic [7:0]  DIV_BASE   = 8'd63;

    // Closed set handed from intake to the solver
    typedef struct packed {
        logic [CNT_MAX_W-1:0] n;
        logic [63:0]          sx;
        logic [63:0]          sy;
        logic [63:0]          sxy;
        logic [63:0]          sxx;
        logic [63:0]          syy;
        logic                 ovf;
    } t_snap;

    // Shared arithmetic unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  sh;
        logic        rnd;
        logic [40:0] cap;
    } t_alu_req;

    // Solver sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NSXX,
        ST_SXSX,
        ST_NSYY,
        ST_SYSY,
        ST_NSXY,
        ST_SXSY,
        ST_CHECK,
        ST_SLOPE,
        ST_NORMA,
        ST_NORMB,
        ST_SQRTA,
        ST_SQRTB,
        ST_RARB,
        ST_CORR,
        ST_SLSX,
        ST_ICPT,
        ST_DIVX,
        ST_SQRX,
        ST_DIVY,
        ST_SQRY,
        ST_OUT
    } t_state;

endpackage

/* hdl/regression_correlation_stats.sv */
// Top level: streaming least-squares regression and Pearson correlation statistics.
//
// Pairs are taken one per clock whenever start is high and busy is low; the
// intake folds each pair into the running sums in the same cycle. A pair with
// i_last_pair closes the set: its sums go into a two-entry queue and the
// accumulators clear, so the next set can stream in at once. busy is high only
// while both queue entries hold sets not yet taken by the solver. The solver
// works one set at a time on a single shared iterative unit (shift-add
// multiply, restoring divide, bit-pair square root): six products for the
// variances and covariance, divides with extra fraction-bit steps, roots,
// and one step per bit pair to normalize each variance before its root. An
// empty set skips all steps after the products, and a zero variance skips
// the slope, normalization, roots and correlation. o_done is high for
// exactly one
// cycle with all result fields valid; the receiver cannot stall it, and the
// fields hold their values until the solver takes up the next set.
module regression_correlation_stats import rcs_pkg::*; #(
    parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  logic                          i_last_pair,
    output logic                          o_done,
    output logic signed [31:0]            o_slope,
    output logic signed [31:0]            o_intercept,
    output logic signed [15:0]            o_correlation,
    output logic [15:0]                   o_deviation_x,
    output logic [15:0]                   o_deviation_y,
    output logic [10:0]                   o_pair_count,
    output logic                          o_degenerate,
    output logic                          o_overflowed
);

    logic        accept, push, pop, full, empty;
    t_snap       snap, head;
    logic        alu_start, alu_done;
    t_alu_req    alu_req;
    logic [63:0] alu_res;

    assign busy   = full;
    assign accept = start & !busy;

    // Intake and accumulation
    rcs_front #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_x      (i_x_sample),
        .i_y      (i_y_sample),
        .i_last   (i_last_pair),
        .o_push   (push),
        .o_snap   (snap)
    );

    // Closed sets awaiting the solver
    rcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_snap  (snap),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    // Solver sequencer
    rcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_alu_start   (alu_start),
        .o_alu_req     (alu_req),
        .i_alu_done    (alu_done),
        .i_alu_res     (alu_res),
        .o_done        (o_done),
        .o_slope       (o_slope),
        .o_intercept   (o_intercept),
        .o_correlation (o_correlation),
        .o_deviation_x (o_deviation_x),
        .o_deviation_y (o_deviation_y),
        .o_pair_count  (o_pair_count),
        .o_degenerate  (o_degenerate),
        .o_overflowed  (o_overflowed)
    );

    // Shared arithmetic unit
    rcs_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_req   (alu_req),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

endmodule

/* hdl/rcs_front.sv */
// Intake: classifies each pair (take or drop) and accumulates the set's sums.
module rcs_front import rcs_pkg::*; #(
    parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic                          i_last,
    output logic                          o_push,
    output t_snap                         o_snap
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int PRD_W = 2 * SAMPLE_BITS + CNT_W;

    logic        [CNT_W-1:0] r_cnt, n_cnt;
    logic signed [SUM_W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [PRD_W-1:0] r_sxy, n_sxy, r_sxx, n_sxx, r_syy, n_syy;
    logic                    r_ovf, n_ovf;

    logic signed [2*SAMPLE_BITS-1:0] t_xy, t_xx, t_yy;
    logic                            t_full;

    assign t_xy   = i_x * i_y;
    assign t_xx   = i_x * i_x;
    assign t_yy   = i_y * i_y;
    assign t_full = (r_cnt == CNT_W'(MAX_PAIRS));

    // Updated sums with this item folded in (a pair on a full set is dropped)
    always_comb begin
        n_cnt = r_cnt;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxy = r_sxy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        n_ovf = r_ovf;
        if (t_full) begin
            n_ovf = 1'b1;
        end else begin
            n_cnt = r_cnt + 1'b1;
            n_sx  = r_sx + SUM_W'(i_x);
            n_sy  = r_sy + SUM_W'(i_y);
            n_sxy = r_sxy + PRD_W'(t_xy);
            n_sxx = r_sxx + PRD_W'(t_xx);
            n_syy = r_syy + PRD_W'(t_yy);
        end
    end

    // Closed set goes to the queue
    assign o_push     = i_accept & i_last;
    assign o_snap.n   = CNT_MAX_W'(n_cnt);
    assign o_snap.sx  = 64'(n_sx);
    assign o_snap.sy  = 64'(n_sy);
    assign o_snap.sxy = 64'(n_sxy);
    assign o_snap.sxx = 64'(n_sxx);
    assign o_snap.syy = 64'(n_syy);
    assign o_snap.ovf = n_ovf;

    // Accumulators: cleared by reset and after a set closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_ovf <= 1'b0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxy <= n_sxy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_ovf <= n_ovf;
        end
    end

endmodule

/* hdl/rcs_queue.sv */
// Short queue of closed sets between intake and solver.
module rcs_queue import rcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_snap,
    input  logic  i_pop,
    output t_snap o_head,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_snap            r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_snap;
        end
    end

endmodule

/* hdl/rcs_alu.sv */
// Shared iterative unit: shift-add multiply, restoring divide with optional rounding, integer root.
module rcs_alu import rcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_alu_req    i_req,
    output logic        o_done,
    output logic [63:0] o_res
);

    logic        r_busy, n_busy, r_done, n_done;
    t_op         r_op, n_op;
    logic [63:0] r_acc, n_acc, r_opa, n_opa, r_opb, n_opb;
    logic [63:0] r_rem, n_rem, r_bit, n_bit, r_res, n_res;
    logic [40:0] r_q, n_q, r_cap, n_cap;
    logic        r_sat, n_sat, r_rnd, n_rnd;
    logic [7:0]  r_cnt, n_cnt, r_last, n_last;

    logic [64:0] t_trial, t_sum, t_twice;
    logic [41:0] t_q2;
    logic [40:0] t_qf;
    logic        t_qbit;
    logic [63:0] t_out;

    // One step per cycle of the selected operation
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_op    = r_op;
        n_acc   = r_acc;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_res   = r_res;
        n_q     = r_q;
        n_cap   = r_cap;
        n_sat   = r_sat;
        n_rnd   = r_rnd;
        n_cnt   = r_cnt;
        n_last  = r_last;
        t_trial = '0;
        t_sum   = '0;
        t_twice = '0;
        t_q2    = '0;
        t_qf    = '0;
        t_qbit  = 1'b0;
        t_out   = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_opa  = i_req.a;
            n_opb  = i_req.b;
            n_cap  = i_req.cap;
            n_rnd  = i_req.rnd;
            n_acc  = '0;
            n_rem  = (i_req.op == OP_SQRT) ? i_req.a : '0;
            n_q    = '0;
            n_sat  = 1'b0;
            n_bit  = SQRT_TOP;
            n_cnt  = '0;
            unique case (i_req.op)
                OP_MUL:  n_last = MUL_LAST;
                OP_SQRT: n_last = SQRT_LAST;
                OP_DIV:  n_last = DIV_BASE + 8'(i_req.sh);
                default: n_last = MUL_LAST;
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            unique case (r_op)
                OP_MUL: begin
                    n_acc = r_acc + (r_opb[0] ? r_opa : 64'd0);
                    n_opa = r_opa << 1;
                    n_opb = r_opb >> 1;
                    t_out = n_acc;
                end
                OP_DIV: begin
                    // dividend bits enter MSB first, then zeros for the fraction
                    t_trial = {r_rem, r_opa[63]};
                    n_opa   = r_opa << 1;
                    if (t_trial >= {1'b0, r_opb}) begin
                        n_rem  = 64'(t_trial - {1'b0, r_opb});
                        t_qbit = 1'b1;
                    end else begin
                        n_rem  = t_trial[63:0];
                    end
                    t_q2    = {r_q, t_qbit};
                    n_sat   = r_sat | (t_q2[41:40] != 2'b00);
                    n_q     = t_q2[40:0];
                    // round half up on magnitude, then clamp
                    t_twice = {n_rem, 1'b0};
                    t_qf    = n_sat ? Q_SAT
                                    : n_q + 41'(r_rnd && (t_twice >= {1'b0, r_opb}));
                    t_out   = 64'((t_qf > r_cap) ? r_cap : t_qf);
                end
                OP_SQRT: begin
                    t_sum = {1'b0, r_acc} + {1'b0, r_bit};
                    if ({1'b0, r_rem} >= t_sum) begin
                        n_rem = r_rem - t_sum[63:0];
                        n_acc = (r_acc >> 1) + r_bit;
                    end else begin
                        n_acc = r_acc >> 1;
                    end
                    n_bit = r_bit >> 2;
                    t_out = n_acc;
                end
                default: begin
                    t_out = '0;
                end
            endcase
            if (r_cnt == r_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_res  = t_out;
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_acc  <= n_acc;
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_res  <= n_res;
        r_q    <= n_q;
        r_cap  <= n_cap;
        r_sat  <= n_sat;
        r_rnd  <= n_rnd;
        r_cnt  <= n_cnt;
        r_last <= n_last;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* hdl/rcs_back.sv */
// Solver: sequences the arithmetic unit over one closed set and presents the result.
module rcs_back import rcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_snap              i_head,
    output logic               o_pop,
    output logic               o_alu_start,
    output t_alu_req           o_alu_req,
    input  logic               i_alu_done,
    input  logic [63:0]        i_alu_res,
    output logic               o_done,
    output logic signed [31:0] o_slope,
    output logic signed [31:0] o_intercept,
    output logic signed [15:0] o_correlation,
    output logic [15:0]        o_deviation_x,
    output logic [15:0]        o_deviation_y,
    output logic [10:0]        o_pair_count,
    output logic               o_degenerate,
    output logic               o_overflowed
);

    t_state r_state, n_state;
    logic   r_wait;

    logic [CNT_MAX_W-1:0] r_n;
    logic [63:0] r_sx, r_sy, r_sxy, r_sxx, r_syy;
    logic [63:0] r_vxx, r_vyy, r_nxy, r_t, r_va, r_vb;
    logic [31:0] r_ra, r_rb, r_slope, r_icpt;
    logic [15:0] r_corr, r_devx, r_devy;
    logic [4:0]  r_ka, r_kb;
    logic        r_ovf, r_degen;

    logic        t_op_st, t_degen;
    logic [63:0] t_n64, t_diff, t_num, t_nxy_mag, t_num_mag, t_slope64, t_half;
    logic [33:0] t_nn;

    assign t_n64     = 64'(r_n);
    assign t_nn      = 34'(r_n) * 34'(r_n);
    assign t_diff    = r_t - i_alu_res;
    assign t_nxy_mag = r_nxy[63] ? 64'(64'd0 - r_nxy) : r_nxy;
    assign t_slope64 = 64'(signed'(r_slope));
    assign t_num     = (r_sy << 16) - r_t;
    assign t_num_mag = t_num[63] ? 64'(64'd0 - t_num) : t_num;
    assign t_half    = (i_alu_res + 64'd1) >> 1;
    assign t_degen   = (r_n == '0) || (r_vxx == '0) || (r_vyy == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_empty) n_state = ST_NSXX;
            ST_NSXX:  if (i_alu_done) n_state = ST_SXSX;
            ST_SXSX:  if (i_alu_done) n_state = ST_NSYY;
            ST_NSYY:  if (i_alu_done) n_state = ST_SYSY;
            ST_SYSY:  if (i_alu_done) n_state = ST_NSXY;
            ST_NSXY:  if (i_alu_done) n_state = ST_SXSY;
            ST_SXSY:  if (i_alu_done) n_state = ST_CHECK;
            ST_CHECK: begin
                priority if (r_n == '0) n_state = ST_OUT;
                else if (t_degen)       n_state = ST_SLSX;
                else                    n_state = ST_SLOPE;
            end
            ST_SLOPE: if (i_alu_done) n_state = ST_NORMA;
            ST_NORMA: if (r_va >= NORM_LIM) n_state = ST_NORMB;
            ST_NORMB: if (r_vb >= NORM_LIM) n_state = ST_SQRTA;
            ST_SQRTA: if (i_alu_done) n_state = ST_SQRTB;
            ST_SQRTB: if (i_alu_done) n_state = ST_RARB;
            ST_RARB:  if (i_alu_done) n_state = ST_CORR;
            ST_CORR:  if (i_alu_done) n_state = ST_SLSX;
            ST_SLSX:  if (i_alu_done) n_state = ST_ICPT;
            ST_ICPT:  if (i_alu_done) n_state = ST_DIVX;
            ST_DIVX:  if (i_alu_done) n_state = ST_SQRX;
            ST_SQRX:  if (i_alu_done) n_state = ST_DIVY;
            ST_DIVY:  if (i_alu_done) n_state = ST_SQRY;
            ST_SQRY:  if (i_alu_done) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs: queue pop, unit requests, result strobe
    always_comb begin
        o_pop     = 1'b0;
        o_done    = 1'b0;
        t_op_st   = 1'b0;
        o_alu_req = '{op: OP_MUL, a: '0, b: '0, sh: '0, rnd: 1'b0, cap: '0};
        unique case (r_state)
            ST_IDLE: o_pop = !i_empty;
            ST_NSXX: begin
                t_op_st = 1'b1;
                o_alu_req.a = t_n64;
                o_alu_req.b = r_sxx;
            end
            ST_SXSX: begin
                t_op_st = 1'b1;
                o_alu_req.a = r_sx;
                o_alu_req.b = r_sx;
            end
            ST_NSYY: begin
                t_op_st = 1'b1;
                o_alu_req.a = t_n64;
                o_alu_req.b = r_syy;
            end
            ST_SYSY: begin
                t_op_st = 1'b1;
                o_alu_req.a = r_sy;
                o_alu_req.b = r_sy;
            end
            ST_NSXY: begin
                t_op_st = 1'b1;
                o_alu_req.a = t_n64;
                o_alu_req.b = r_sxy;
            end
            ST_SXSY: begin
                t_op_st = 1'b1;
                o_alu_req.a = r_sx;
                o_alu_req.b = r_sy;
            end
            ST_SLOPE: begin
                t_op_st = 1'b1;
                o_alu_req.op  = OP_DIV;
                o_alu_req.a   = t_nxy_mag;
                o_alu_req.b   = r_vxx;
                o_alu_req.sh  = SLOPE_FRAC;
                o_alu_req.rnd = 1'b1;
                o_alu_req.cap = r_nxy[63] ? CAP_NEG32 : CAP_POS32;
            end
            ST_SQRTA: begin
                t_op_st = 1'b1;
                o_alu_req.op = OP_SQRT;
                o_alu_req.a  = r_va;
            end
            ST_SQRTB: begin
                t_op_st = 1'b1;
                o_alu_req.op = OP_SQRT;
                o_alu_req.a  = r_vb;
            end
            ST_RARB: begin
                t_op_st = 1'b1;
                o_alu_req.a = 64'(r_ra);
                o_alu_req.b = 64'(r_rb);
            end
            ST_CORR: begin
                t_op_st = 1'b1;
                o_alu_req.op  = OP_DIV;
                o_alu_req.a   = t_nxy_mag;
                o_alu_req.b   = r_t;
                o_alu_req.sh  = 7'(r_ka) + 7'(r_kb) + CORR_FRAC;
                o_alu_req.rnd = 1'b1;
                o_alu_req.cap = CAP_CORR;
            end
            ST_SLSX: begin
                t_op_st = 1'b1;
                o_alu_req.a = t_slope64;
                o_alu_req.b = r_sx;
            end
            ST_ICPT: begin
                t_op_st = 1'b1;
                o_alu_req.op  = OP_DIV;
                o_alu_req.a   = t_num_mag;
                o_alu_req.b   = t_n64 << 8;
                o_alu_req.rnd = 1'b1;
                o_alu_req.cap = t_num[63] ? CAP_NEG32 : CAP_POS32;
            end
            ST_DIVX: begin
                t_op_st = 1'b1;
                o_alu_req.op  = OP_DIV;
                o_alu_req.a   = r_vxx << 2;
                o_alu_req.b   = 64'(t_nn);
                o_alu_req.cap = Q_SAT;
            end
            ST_DIVY: begin
                t_op_st = 1'b1;
                o_alu_req.op  = OP_DIV;
                o_alu_req.a   = r_vyy << 2;
                o_alu_req.b   = 64'(t_nn);
                o_alu_req.cap = Q_SAT;
            end
            ST_SQRX, ST_SQRY: begin
                t_op_st = 1'b1;
                o_alu_req.op = OP_SQRT;
                o_alu_req.a  = r_t;
            end
            ST_OUT: o_done = 1'b1;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_alu_start = t_op_st & !r_wait;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_alu_start) begin
                r_wait <= 1'b1;
            end else if (i_alu_done) begin
                r_wait <= 1'b0;
            end
        end
    end

    // Working registers, written as each step finishes
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_n     <= i_head.n;
                    r_sx    <= i_head.sx;
                    r_sy    <= i_head.sy;
                    r_sxy   <= i_head.sxy;
                    r_sxx   <= i_head.sxx;
                    r_syy   <= i_head.syy;
                    r_ovf   <= i_head.ovf;
                    r_slope <= '0;
                    r_icpt  <= '0;
                    r_corr  <= '0;
                    r_devx  <= '0;
                    r_devy  <= '0;
                end
            end
            ST_NSXX, ST_NSYY, ST_NSXY, ST_RARB, ST_SLSX, ST_DIVX, ST_DIVY: begin
                if (i_alu_done) r_t <= i_alu_res;
            end
            // a variance that reads negative counts as zero
            ST_SXSX: if (i_alu_done) r_vxx <= t_diff[63] ? 64'd0 : t_diff;
            ST_SYSY: if (i_alu_done) r_vyy <= t_diff[63] ? 64'd0 : t_diff;
            ST_SXSY: if (i_alu_done) r_nxy <= t_diff;
            ST_CHECK: begin
                r_degen <= t_degen;
                r_va    <= r_vxx;
                r_vb    <= r_vyy;
                r_ka    <= '0;
                r_kb    <= '0;
            end
            ST_SLOPE: begin
                if (i_alu_done) begin
                    r_slope <= r_nxy[63] ? 32'(64'd0 - i_alu_res) : i_alu_res[31:0];
                end
            end
            // normalize into [2^60, 2^62) two bits at a time
            ST_NORMA: begin
                if (r_va < NORM_LIM) begin
                    r_va <= r_va << 2;
                    r_ka <= r_ka + 1'b1;
                end
            end
            ST_NORMB: begin
                if (r_vb < NORM_LIM) begin
                    r_vb <= r_vb << 2;
                    r_kb <= r_kb + 1'b1;
                end
            end
            ST_SQRTA: if (i_alu_done) r_ra <= i_alu_res[31:0];
            ST_SQRTB: if (i_alu_done) r_rb <= i_alu_res[31:0];
            ST_CORR: begin
                if (i_alu_done) begin
                    r_corr <= r_nxy[63] ? 16'(64'd0 - i_alu_res) : i_alu_res[15:0];
                end
            end
            ST_ICPT: begin
                if (i_alu_done) begin
                    r_icpt <= t_num[63] ? 32'(64'd0 - i_alu_res) : i_alu_res[31:0];
                end
            end
            ST_SQRX: if (i_alu_done) r_devx <= (t_half > DEV_MAX) ? 16'hFFFF : t_half[15:0];
            ST_SQRY: if (i_alu_done) r_devy <= (t_half > DEV_MAX) ? 16'hFFFF : t_half[15:0];
            ST_OUT: begin
                r_t <= r_t;
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_slope       = r_slope;
    assign o_intercept   = r_icpt;
    assign o_correlation = r_corr;
    assign o_deviation_x = r_devx;
    assign o_deviation_y = r_devy;
    assign o_pair_count  = r_n[10:0];
    assign o_degenerate  = r_degen;
    assign o_overflowed  = r_ovf;

endmodule
